// ----- sv/ld_pkg.sv -----
package ld_pkg;

    localparam int RECORD_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(RECORD_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int SAMPLE_W     = 16;
    localparam int FRAC_W       = 16;
    localparam int COEF_W       = SAMPLE_W + FRAC_W + 8;
    localparam int RES_W        = 18;

    localparam int SX_W  = 24;
    localparam int SXX_W = 36;
    localparam int SY_W  = 28;
    localparam int SXY_W = 40;

    localparam int OPND_W   = 41;
    localparam int MAG_W    = OPND_W - 1;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int DEN_W    = 48;
    localparam int NUM_W    = 66;
    localparam int DIVD_W   = NUM_W - 1 + FRAC_W;
    localparam int STEP_W   = 7;
    localparam int MUL_STEPS = MAG_W;
    localparam int DIV_STEPS = DIVD_W;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DEGEN  = 2'd1;
    localparam logic [1:0] ST_NODATA = 2'd2;

    typedef struct packed {
        logic start;
        logic done;
    } fit_ctl_t;

    function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [DIVD_W+1:0] v);
        logic fits;
        fits = (&v[DIVD_W+1:COEF_W-1]) | ~(|v[DIVD_W+1:COEF_W-1]);
        if (fits)
            return v[COEF_W-1:0];
        else if (v[DIVD_W+1])
            return {1'b1, {(COEF_W-1){1'b0}}};
        else
            return {1'b0, {(COEF_W-1){1'b1}}};
    endfunction

    function automatic logic signed [RES_W-1:0] sat_res(input logic signed [COEF_W-1:0] v);
        logic fits;
        fits = (&v[COEF_W-1:RES_W-1]) | ~(|v[COEF_W-1:RES_W-1]);
        if (fits)
            return v[RES_W-1:0];
        else if (v[COEF_W-1])
            return {1'b1, {(RES_W-1){1'b0}}};
        else
            return {1'b0, {(RES_W-1){1'b1}}};
    endfunction

endpackage

// ----- sv/ld_ram.sv -----
module ld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/ld_fit.sv -----
module ld_fit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [ld_pkg::CNT_W-1:0]            n,
    input  logic [ld_pkg::SX_W-1:0]             sx,
    input  logic [ld_pkg::SXX_W-1:0]            sxx,
    input  logic signed [ld_pkg::SY_W-1:0]      sy,
    input  logic signed [ld_pkg::SXY_W-1:0]     sxy,
    output logic                                done,
    output logic signed [ld_pkg::COEF_W-1:0]    slope,
    output logic signed [ld_pkg::COEF_W-1:0]    intercept
);
    import ld_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_MINIT, F_MUL, F_ACC, F_DINIT, F_DIV, F_RND} fstate_t;

    fstate_t                   state_reg;
    logic [2:0]                k_reg;
    logic [STEP_W-1:0]         cnt_reg;
    logic [PROD_W-1:0]         ma_reg;
    logic [MAG_W-1:0]          mb_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      pneg_reg;
    logic signed [PROD_W:0]    t_reg;
    logic [DEN_W-1:0]          d_reg;
    logic signed [NUM_W-1:0]   ns_reg;
    logic signed [NUM_W-1:0]   ni_reg;
    logic                      sel_reg;
    logic [DIVD_W-1:0]         dm_reg;
    logic [DIVD_W-1:0]         dq_reg;
    logic [DEN_W-1:0]          dr_reg;
    logic                      dneg_reg;
    logic                      done_reg;
    logic signed [COEF_W-1:0]  slope_reg;
    logic signed [COEF_W-1:0]  intercept_reg;

    logic signed [OPND_W-1:0]  opa;
    logic signed [OPND_W-1:0]  opb;
    logic signed [OPND_W-1:0]  abs_a;
    logic signed [OPND_W-1:0]  abs_b;
    logic signed [PROD_W:0]    p_signed;
    logic signed [PROD_W:0]    diff;
    logic signed [NUM_W-1:0]   num;
    logic [NUM_W-1:0]          num_mag;
    logic [DEN_W:0]            rs;
    logic                      ge;
    logic [DIVD_W:0]           q1;
    logic signed [DIVD_W+1:0]  q_signed;

    always_comb
    begin
        case (k_reg)
            3'd0:    begin opa = OPND_W'(n);   opb = OPND_W'(sxx); end
            3'd1:    begin opa = OPND_W'(sx);  opb = OPND_W'(sx);  end
            3'd2:    begin opa = OPND_W'(n);   opb = OPND_W'(sxy); end
            3'd3:    begin opa = OPND_W'(sx);  opb = OPND_W'(sy);  end
            3'd4:    begin opa = OPND_W'(sxx); opb = OPND_W'(sy);  end
            default: begin opa = OPND_W'(sx);  opb = OPND_W'(sxy); end
        endcase
        abs_a    = opa[OPND_W-1] ? -opa : opa;
        abs_b    = opb[OPND_W-1] ? -opb : opb;
        p_signed = pneg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
        diff     = t_reg - p_signed;
        num      = sel_reg ? ni_reg : ns_reg;
        num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rs       = {dr_reg, dm_reg[DIVD_W-1]};
        ge       = rs >= {1'b0, d_reg};
        q1       = {1'b0, dq_reg} + (DIVD_W+1)'({dr_reg, 1'b0} >= {1'b0, d_reg});
        q_signed = dneg_reg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            done_reg      <= 1'b0;
            k_reg         <= '0;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            slope_reg     <= '0;
            intercept_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        k_reg     <= '0;
                        state_reg <= F_MINIT;
                    end
                end
                F_MINIT:
                begin
                    ma_reg    <= PROD_W'(abs_a[MAG_W-1:0]);
                    mb_reg    <= abs_b[MAG_W-1:0];
                    prod_reg  <= '0;
                    pneg_reg  <= opa[OPND_W-1] ^ opb[OPND_W-1];
                    cnt_reg   <= STEP_W'(MUL_STEPS);
                    state_reg <= F_MUL;
                end
                F_MUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= F_ACC;
                    end
                    else
                    begin
                        if (mb_reg[0])
                        begin
                            prod_reg <= prod_reg + ma_reg;
                        end
                        ma_reg  <= ma_reg << 1;
                        mb_reg  <= mb_reg >> 1;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                F_ACC:
                begin
                    case (k_reg)
                        3'd1:    d_reg  <= diff[DEN_W-1:0];
                        3'd3:    ns_reg <= diff[NUM_W-1:0];
                        3'd5:    ni_reg <= diff[NUM_W-1:0];
                        default: t_reg  <= p_signed;
                    endcase
                    if (k_reg == 3'd5)
                    begin
                        sel_reg   <= 1'b0;
                        state_reg <= F_DINIT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= F_MINIT;
                    end
                end
                F_DINIT:
                begin
                    dneg_reg  <= num[NUM_W-1];
                    dm_reg    <= {num_mag[NUM_W-2:0], {FRAC_W{1'b0}}};
                    dq_reg    <= '0;
                    dr_reg    <= '0;
                    cnt_reg   <= STEP_W'(DIV_STEPS);
                    state_reg <= F_DIV;
                end
                F_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= F_RND;
                    end
                    else
                    begin
                        dr_reg  <= ge ? DEN_W'(rs - {1'b0, d_reg}) : rs[DEN_W-1:0];
                        dq_reg  <= {dq_reg[DIVD_W-2:0], ge};
                        dm_reg  <= dm_reg << 1;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                F_RND:
                begin
                    if (sel_reg)
                    begin
                        intercept_reg <= sat_coef(q_signed);
                        done_reg      <= 1'b1;
                        state_reg     <= F_IDLE;
                    end
                    else
                    begin
                        slope_reg <= sat_coef(q_signed);
                        sel_reg   <= 1'b1;
                        state_reg <= F_DINIT;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign slope     = slope_reg;
    assign intercept = intercept_reg;

endmodule

// ----- sv/linear_detrend.sv -----
// Least-squares linear detrend of one record of signed 16-bit samples.
// Input channel (in_valid/in_ready): opcode 0 pushes sample, opcode 1 pulls
// the next residual. Output channel (out_valid/out_ready) carries residual,
// last_residual and status; pushes give no output item.
// Pushes stream at one item per cycle while no pull or fit is in progress.
// The first pull of a record with at least two samples runs the fit: a serial
// shift-add multiplier forms six 80-bit products and a restoring divider produces
// slope and intercept. Each pull then steps through sample RAM read, slope*index
// multiply, sum and saturate, and load of the output register; with nothing to
// read it goes from the read step straight to the load.
// The output register decouples the sides: pushes are still accepted while
// a residual waits; a pull waits in its last step until the register frees.
// Reset (rst_n, asynchronous) clears count, sums, index and coefficients;
// sample RAM contents are not cleared.
module linear_detrend
    import ld_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic signed [ld_pkg::SAMPLE_W-1:0] sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ld_pkg::RES_W-1:0]    residual,
    output logic                               last_residual,
    output logic [1:0]                         status
);

    typedef enum logic [2:0] {S_IDLE, S_FIT, S_RD, S_MUL, S_SUM, S_OUT} state_t;

    state_t                         state_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               ridx_reg;
    logic [SX_W-1:0]                sx_reg;
    logic [SXX_W-1:0]               sxx_reg;
    logic signed [SY_W-1:0]         sy_reg;
    logic signed [SXY_W-1:0]        sxy_reg;
    logic                           emitting_reg;
    logic signed [SAMPLE_W-1:0]     y_reg;
    logic signed [SAMPLE_W+CNT_W+FRAC_W+8:0] prod_reg;
    logic                           last_reg;
    logic                           degen_reg;
    logic signed [RES_W-1:0]        res_reg;
    logic [1:0]                     stat_reg;
    logic                           out_valid_reg;
    logic signed [RES_W-1:0]        out_res_reg;
    logic                           out_last_reg;
    logic [1:0]                     out_stat_reg;

    fit_ctl_t                       fit_ctl;
    logic signed [COEF_W-1:0]       slope;
    logic signed [COEF_W-1:0]       intercept;

    logic                           accept;
    logic                           push;
    logic                           pull;
    logic                           push_ok;
    logic [CNT_W-1:0]               base_i;
    logic [2*ADDR_W-1:0]            ii;
    logic signed [SAMPLE_W+CNT_W-1:0] iy;
    logic [SAMPLE_W-1:0]            rdata;
    logic signed [SAMPLE_W+CNT_W+FRAC_W+10:0] acc;
    logic signed [COEF_W-1:0]       shifted;
    logic                           out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign push     = accept && (opcode == OP_PUSH);
    assign pull     = accept && (opcode == OP_PULL);
    assign base_i   = emitting_reg ? '0 : count_reg;
    assign push_ok  = push && (base_i < CNT_W'(RECORD_DEPTH));
    assign ii       = base_i[ADDR_W-1:0] * base_i[ADDR_W-1:0];
    assign iy       = $signed({1'b0, base_i}) * sample;
    assign fit_ctl.start = pull && !emitting_reg && (count_reg >= CNT_W'(2));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        acc = ($signed({{(CNT_W+10){y_reg[SAMPLE_W-1]}}, y_reg}) <<< FRAC_W)
              - prod_reg - intercept
              + $signed((SAMPLE_W+CNT_W+FRAC_W+11)'(1) <<< (FRAC_W-1));
        shifted = COEF_W'(acc >>> FRAC_W);
    end

    ld_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RECORD_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (push_ok),
        .waddr (base_i[ADDR_W-1:0]),
        .wdata (sample),
        .re    (state_reg == S_RD),
        .raddr (ridx_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    ld_fit u_fit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (fit_ctl.start),
        .n         (count_reg),
        .sx        (sx_reg),
        .sxx       (sxx_reg),
        .sy        (sy_reg),
        .sxy       (sxy_reg),
        .done      (fit_ctl.done),
        .slope     (slope),
        .intercept (intercept)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ridx_reg      <= '0;
            sx_reg        <= '0;
            sxx_reg       <= '0;
            sy_reg        <= '0;
            sxy_reg       <= '0;
            emitting_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (push)
                    begin
                        // a new record starts at index 0; sums restart via the muxes below
                        if (emitting_reg)
                        begin
                            emitting_reg <= 1'b0;
                            ridx_reg     <= '0;
                        end
                        if (push_ok)
                        begin
                            count_reg <= base_i + 1'b1;
                            sx_reg    <= (emitting_reg ? '0 : sx_reg) + SX_W'(base_i);
                            sxx_reg   <= (emitting_reg ? '0 : sxx_reg) + SXX_W'(ii);
                            sy_reg    <= (emitting_reg ? '0 : sy_reg) + SY_W'(sample);
                            sxy_reg   <= (emitting_reg ? '0 : sxy_reg) + SXY_W'(iy);
                        end
                    end
                    else if (pull)
                    begin
                        emitting_reg <= 1'b1;
                        if (!emitting_reg)
                        begin
                            ridx_reg <= '0;
                        end
                        state_reg <= fit_ctl.start ? S_FIT : S_RD;
                    end
                end
                S_FIT:
                begin
                    if (fit_ctl.done)
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    if (ridx_reg >= count_reg)
                    begin
                        res_reg   <= '0;
                        last_reg  <= 1'b0;
                        stat_reg  <= ST_NODATA;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    y_reg     <= rdata;
                    prod_reg  <= slope * $signed({1'b0, ridx_reg});
                    last_reg  <= (ridx_reg + 1'b1) == count_reg;
                    degen_reg <= count_reg < CNT_W'(2);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (degen_reg)
                    begin
                        res_reg  <= RES_W'(y_reg);
                        stat_reg <= ST_DEGEN;
                    end
                    else
                    begin
                        res_reg  <= sat_res(shifted);
                        stat_reg <= ST_OK;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_res_reg   <= res_reg;
                        out_last_reg  <= last_reg;
                        out_stat_reg  <= stat_reg;
                        if (stat_reg != ST_NODATA)
                        begin
                            ridx_reg <= ridx_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign residual      = out_res_reg;
    assign last_residual = out_last_reg;
    assign status        = out_stat_reg;

`ifndef NO_ASSERTIONS
    a_fit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIT) |-> !in_ready)
        else $error("input accepted during fit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RECORD_DEPTH))
        else $error("sample count beyond record depth");

    a_nodata_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_NODATA) |-> (residual == '0 && !last_residual))
        else $error("no-data item carries payload");

    a_fit_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        fit_ctl.start |=> (state_reg == S_FIT))
        else $error("fit started without waiting");
`endif

endmodule
